/* src/mwbm_pkg.sv */
// Shared types and sizing constants for the wildcard byte matcher.
// No dependencies; every other file refers to this package by scoped names.
package mwbm_pkg;

    // Table and stream sizing
    localparam int PATTERNS        = 4;
    localparam int MAX_PATTERN_LEN = 16;
    localparam int OFFSET_BITS     = 32;
    localparam int MAX_HITS        = 4;
    localparam int HIST_DEPTH      = MAX_PATTERN_LEN - 1;

    // Derived widths
    localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
    localparam int IDX_W  = $clog2(MAX_PATTERN_LEN);
    localparam int PIDX_W = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;

    // Hit queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_LENGTH  = 2'd1,
        REQ_DATA    = 2'd2,
        REQ_RESTART = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type  req_type;
        logic [1:0] pattern_index;
        logic [3:0] byte_position;
        logic [7:0] pattern_byte;
        logic       care;
        logic [4:0] pattern_length;
        logic [7:0] data_byte;
    } t_req;

    typedef struct packed {
        logic [1:0]  hit_pattern;
        logic [31:0] hit_offset;
        logic        last_hit;
    } t_hit;

    // One queue entry: the hits caused by one data byte
    typedef struct packed {
        logic [PATTERNS-1:0]            mask;
        logic [OFFSET_BITS-1:0]         base;
        logic [PATTERNS-1:0][IDX_W-1:0] span;
    } t_q_ent;

    typedef struct packed {
        logic   push;
        t_q_ent ent;
    } t_q_wr;

    typedef struct packed {
        logic   empty;
        t_q_ent ent;
    } t_q_rd;

endpackage

/* src/mwbm_front.sv */
// Front end: takes requests, keeps the pattern table, history and offset,
// compares all patterns in parallel and queues the hit mask. Uses mwbm_pkg.
module mwbm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_acc,
    input  mwbm_pkg::t_req i_req,
    output mwbm_pkg::t_q_wr o_wr
);

    logic [7:0] r_val [mwbm_pkg::PATTERNS][mwbm_pkg::MAX_PATTERN_LEN];
    logic [mwbm_pkg::MAX_PATTERN_LEN-1:0] r_care [mwbm_pkg::PATTERNS];
    logic [mwbm_pkg::LEN_W-1:0] r_len [mwbm_pkg::PATTERNS];
    logic [7:0] r_hist [mwbm_pkg::HIST_DEPTH];
    logic [mwbm_pkg::OFFSET_BITS-1:0] r_offset;
    logic [mwbm_pkg::OFFSET_BITS-1:0] n_offset;

    logic [7:0] w_win [mwbm_pkg::MAX_PATTERN_LEN];
    logic [mwbm_pkg::PATTERNS-1:0] w_raw;
    logic [mwbm_pkg::PATTERNS-1:0] w_mask;
    logic [mwbm_pkg::LEN_W-1:0] w_plen;

    // Window: slot 0 is the incoming byte, slot j the byte j back
    always_comb begin
        w_win[0] = i_req.data_byte;
        for (int j = 1; j < mwbm_pkg::MAX_PATTERN_LEN; j++) begin
            w_win[j] = r_hist[j-1];
        end
    end

    always_comb begin
        logic [mwbm_pkg::IDX_W-1:0] v_sel;
        int                         v_n;
        v_sel = '0;
        v_n   = 0;
        for (int p = 0; p < mwbm_pkg::PATTERNS; p++) begin
            w_raw[p] = (r_len[p] != '0) &&
                (r_offset >= mwbm_pkg::OFFSET_BITS'(r_len[p] - mwbm_pkg::LEN_W'(1)));
            for (int k = 0; k < mwbm_pkg::MAX_PATTERN_LEN; k++) begin
                if ((mwbm_pkg::LEN_W'(k) < r_len[p]) && r_care[p][k]) begin
                    v_sel = mwbm_pkg::IDX_W'(r_len[p] - mwbm_pkg::LEN_W'(1)
                                             - mwbm_pkg::LEN_W'(k));
                    if (w_win[v_sel] != r_val[p][k]) begin
                        w_raw[p] = 1'b0;
                    end
                end
            end
        end
        // keep only the lowest-index hits up to the per-byte limit
        for (int p = 0; p < mwbm_pkg::PATTERNS; p++) begin
            w_mask[p] = w_raw[p] && (v_n < mwbm_pkg::MAX_HITS);
            if (w_mask[p]) begin
                v_n = v_n + 1;
            end
        end
    end

    always_comb begin
        o_wr.push     = i_acc && (i_req.req_type == mwbm_pkg::REQ_DATA) && (w_mask != '0);
        o_wr.ent.mask = w_mask;
        o_wr.ent.base = r_offset;
        for (int p = 0; p < mwbm_pkg::PATTERNS; p++) begin
            o_wr.ent.span[p] = mwbm_pkg::IDX_W'(r_len[p] - mwbm_pkg::LEN_W'(1));
        end
    end

    // lengths above the table width are clamped
    assign w_plen = (int'(i_req.pattern_length) > mwbm_pkg::MAX_PATTERN_LEN) ?
                    mwbm_pkg::LEN_W'(mwbm_pkg::MAX_PATTERN_LEN) :
                    mwbm_pkg::LEN_W'(i_req.pattern_length);

    assign n_offset = (r_offset == '1) ? r_offset : r_offset + 1'b1;

    // pattern values need no reset: care bits gate them
    always_ff @(posedge i_clk) begin
        if (i_acc && (i_req.req_type == mwbm_pkg::REQ_LOAD)) begin
            for (int p = 0; p < mwbm_pkg::PATTERNS; p++) begin
                for (int k = 0; k < mwbm_pkg::MAX_PATTERN_LEN; k++) begin
                    if ((int'(i_req.pattern_index) == p) &&
                        (int'(i_req.byte_position) == k)) begin
                        r_val[p][k] <= i_req.pattern_byte;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < mwbm_pkg::PATTERNS; p++) begin
                r_care[p] <= '0;
                r_len[p]  <= '0;
            end
            for (int j = 0; j < mwbm_pkg::HIST_DEPTH; j++) begin
                r_hist[j] <= '0;
            end
            r_offset <= '0;
        end else if (i_acc) begin
            case (i_req.req_type)
                mwbm_pkg::REQ_LOAD: begin
                    for (int p = 0; p < mwbm_pkg::PATTERNS; p++) begin
                        for (int k = 0; k < mwbm_pkg::MAX_PATTERN_LEN; k++) begin
                            if ((int'(i_req.pattern_index) == p) &&
                                (int'(i_req.byte_position) == k)) begin
                                r_care[p][k] <= i_req.care;
                            end
                        end
                    end
                end
                mwbm_pkg::REQ_LENGTH: begin
                    for (int p = 0; p < mwbm_pkg::PATTERNS; p++) begin
                        if (int'(i_req.pattern_index) == p) begin
                            r_len[p] <= w_plen;
                        end
                    end
                end
                mwbm_pkg::REQ_DATA: begin
                    r_hist[0] <= i_req.data_byte;
                    for (int j = 1; j < mwbm_pkg::HIST_DEPTH; j++) begin
                        r_hist[j] <= r_hist[j-1];
                    end
                    r_offset <= n_offset;
                end
                mwbm_pkg::REQ_RESTART: begin
                    for (int j = 0; j < mwbm_pkg::HIST_DEPTH; j++) begin
                        r_hist[j] <= '0;
                    end
                    r_offset <= '0;
                end
                default: begin
                    r_offset <= r_offset;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && (i_req.req_type == mwbm_pkg::REQ_RESTART)) |=> (r_offset == '0))
        else $error("offset not cleared by restart");
    a_offset_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && (i_req.req_type == mwbm_pkg::REQ_DATA) && (r_offset == '1))
        |=> (r_offset == '1))
        else $error("offset wrapped");
`endif

endmodule

/* src/mwbm_fifo.sv */
// Short hit queue decoupling the front end from the hit serialiser.
// Uses mwbm_pkg for the entry type and depth.
module mwbm_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mwbm_pkg::t_q_wr  i_wr,
    input  logic             i_pop,
    output logic             o_full,
    output mwbm_pkg::t_q_rd  o_rd
);

    mwbm_pkg::t_q_ent r_mem [mwbm_pkg::QDEPTH];
    logic [mwbm_pkg::QPTR_W-1:0] r_wr;
    logic [mwbm_pkg::QPTR_W-1:0] r_rd;
    logic [mwbm_pkg::QCNT_W-1:0] r_count;
    logic [mwbm_pkg::QPTR_W-1:0] n_wr;
    logic [mwbm_pkg::QPTR_W-1:0] n_rd;

    assign n_wr = (r_wr == mwbm_pkg::QPTR_W'(mwbm_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == mwbm_pkg::QPTR_W'(mwbm_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;

    assign o_full    = (r_count == mwbm_pkg::QCNT_W'(mwbm_pkg::QDEPTH));
    assign o_rd.empty = (r_count == '0);
    assign o_rd.ent   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wr] <= i_wr.ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_wr.push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_wr.push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr.push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.push |-> !o_full)
        else $error("push into full hit queue");
`endif

endmodule

/* src/mwbm_back.sv */
// Back end: walks the hit mask of the queue head, one hit per cycle while the
// output is not stalled, into the output register. Uses mwbm_pkg.
module mwbm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mwbm_pkg::t_q_rd i_rd,
    output logic            o_pop,
    output logic            o_hit_valid,
    input  logic            i_hit_stall,
    output mwbm_pkg::t_hit  o_hit
);

    logic [mwbm_pkg::PATTERNS-1:0] r_done;
    logic                          r_valid;
    mwbm_pkg::t_hit                r_hit;

    logic [mwbm_pkg::PATTERNS-1:0]    w_rem;
    logic [mwbm_pkg::PATTERNS-1:0]    w_one;
    logic [mwbm_pkg::PIDX_W-1:0]      w_sel;
    logic                             w_last;
    logic                             w_load;
    logic [mwbm_pkg::OFFSET_BITS-1:0] w_start;

    assign w_rem = i_rd.ent.mask & ~r_done;

    // lowest remaining pattern first
    always_comb begin
        w_sel = '0;
        for (int p = mwbm_pkg::PATTERNS - 1; p >= 0; p--) begin
            if (w_rem[p]) begin
                w_sel = mwbm_pkg::PIDX_W'(p);
            end
        end
        w_one        = '0;
        w_one[w_sel] = 1'b1;
    end

    assign w_last  = ((w_rem & ~w_one) == '0);
    assign w_start = i_rd.ent.base - mwbm_pkg::OFFSET_BITS'(i_rd.ent.span[w_sel]);
    assign w_load  = !i_rd.empty && (!r_valid || !i_hit_stall);
    assign o_pop   = w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_hit.hit_pattern <= 2'(w_sel);
            r_hit.hit_offset  <= 32'(w_start);
            r_hit.last_hit    <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_done  <= w_last ? '0 : (r_done | w_one);
            end else if (!i_hit_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_hit_valid = r_valid;
    assign o_hit       = r_hit;

`ifndef SYNTHESIS
    a_done_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done != '0) |-> !i_rd.empty)
        else $error("partial hit mask without a queue head");
    a_hits_ascend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_hit_stall && !r_hit.last_hit)
        |=> (r_valid && (r_hit.hit_pattern > $past(r_hit.hit_pattern))))
        else $error("hit sequence of one byte broken");
`endif

endmodule

/* src/multi_pattern_wildcard_byte_matcher_unit.sv */
// Top level of the multi-pattern wildcard byte matcher.
// Instantiates mwbm_front, mwbm_fifo and mwbm_back; types from mwbm_pkg.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------
//  request | in        | i_req_valid / o_req_stall  | i_req (mwbm_pkg::t_req)
//  hit     | out       | o_hit_valid / i_hit_stall  | o_hit (mwbm_pkg::t_hit)
//
// One request is taken every cycle while the hit queue has room; a data byte
// is compared against all patterns in the cycle it is taken.
// A data byte with n hits gives n hits in turn from the serialiser; its first hit
// passes through the hit queue and then the output register. Bytes without hits cost nothing
// downstream.
// The request stall rises only when the four-entry hit queue is full.
// Synchronous active-low reset clears the care bits, lengths, history, offset
// and queue; no clearing pass is needed.
module multi_pattern_wildcard_byte_matcher_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    input  mwbm_pkg::t_req i_req,
    output logic           o_hit_valid,
    input  logic           i_hit_stall,
    output mwbm_pkg::t_hit o_hit
);

    logic             w_acc;
    logic             w_full;
    logic             w_pop;
    mwbm_pkg::t_q_wr  w_wr;
    mwbm_pkg::t_q_rd  w_rd;

    // Back-pressure comes only from the queue; config-type requests are held too
    // while it is full, which keeps stall independent of the payload.
    assign o_req_stall = w_full;
    assign w_acc       = i_req_valid && !w_full;

    // Front end: table writes, history, offset and the parallel compare
    mwbm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_req   (i_req),
        .o_wr    (w_wr)
    );

    // Hit masks wait here so the output side can stall on its own
    mwbm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_rd    (w_rd)
    );

    // Serialiser: one hit per cycle unless the hit side stalls, in rising pattern order, last one flagged
    mwbm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (w_rd),
        .o_pop       (w_pop),
        .o_hit_valid (o_hit_valid),
        .i_hit_stall (i_hit_stall),
        .o_hit       (o_hit)
    );

endmodule

/* tb/tb.sv */
// Self-checking bench for multi_pattern_wildcard_byte_matcher_unit.
// Keeps its own pattern table, byte history and offset to predict every hit.
// Depends on mwbm_pkg and the matcher RTL.
module tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;   // margin for the hit queue and the serialiser to settle
    localparam int HOLDOFF_LEN  = 150;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_req_valid = 1'b0;
    logic           o_req_stall;
    mwbm_pkg::t_req i_req       = '0;
    logic           o_hit_valid;
    logic           i_hit_stall = 1'b0;
    mwbm_pkg::t_hit o_hit;

    multi_pattern_wildcard_byte_matcher_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_hit_valid (o_hit_valid),
        .i_hit_stall (i_hit_stall),
        .o_hit       (o_hit)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Predicted matcher state: pattern table, recent bytes (entry 0 newest)
    // and the index of the next data byte in the stream.
    // ---------------------------------------------------------------------
    logic [7:0] tbl_value [mwbm_pkg::PATTERNS][mwbm_pkg::MAX_PATTERN_LEN];
    logic       tbl_care  [mwbm_pkg::PATTERNS][mwbm_pkg::MAX_PATTERN_LEN];
    logic [mwbm_pkg::LEN_W-1:0]       tbl_len [mwbm_pkg::PATTERNS];
    logic [7:0]                       recent_bytes [mwbm_pkg::HIST_DEPTH];
    logic [mwbm_pkg::OFFSET_BITS-1:0] next_offset;

    mwbm_pkg::t_hit expected_hits [$];   // hits still owed by the block, oldest first
    int   errors         = 0;
    int   reqs_sent      = 0;
    int   cycle_count    = 0;
    int   send_idle_pct  = 0;   // chance per cycle that the sender idles
    int   hit_stall_pct  = 0;   // chance per cycle that the receiver stalls
    int   holdoff_asked  = 0;   // bumped by a test to ask for a long hold-off
    int   holdoff_served = 0;
    int   holdoff_left   = 0;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic void clear_matcher_model();
        foreach (tbl_value[p, k]) begin
            tbl_value[p][k] = '0;
            tbl_care[p][k]  = 1'b0;
        end
        foreach (tbl_len[p]) tbl_len[p] = '0;
        foreach (recent_bytes[i]) recent_bytes[i] = '0;
        next_offset = '0;
    endfunction

    // Apply one accepted request to the model; a data byte queues its hits.
    function automatic void apply_request(input mwbm_pkg::t_req r);
        mwbm_pkg::t_hit found [mwbm_pkg::MAX_HITS];
        int             n_hits;
        int             len;
        bit             ok;
        logic [7:0]     seen;
        n_hits = 0;
        case (r.req_type)
            mwbm_pkg::REQ_LOAD: begin
                tbl_value[r.pattern_index][r.byte_position] = r.pattern_byte;
                tbl_care[r.pattern_index][r.byte_position]  = r.care;
            end
            mwbm_pkg::REQ_LENGTH: begin
                // overlong lengths clamp to the table width
                if (r.pattern_length > mwbm_pkg::MAX_PATTERN_LEN)
                    tbl_len[r.pattern_index] = mwbm_pkg::LEN_W'(mwbm_pkg::MAX_PATTERN_LEN);
                else
                    tbl_len[r.pattern_index] = r.pattern_length;
            end
            mwbm_pkg::REQ_RESTART: begin
                foreach (recent_bytes[i]) recent_bytes[i] = '0;
                next_offset = '0;
            end
            mwbm_pkg::REQ_DATA: begin
                for (int p = 0; p < mwbm_pkg::PATTERNS && n_hits < mwbm_pkg::MAX_HITS;
                     p++) begin
                    len = tbl_len[p];
                    // disabled, or the stream is still shorter than the window
                    if (len == 0 || next_offset < mwbm_pkg::OFFSET_BITS'(len - 1)) continue;
                    ok = 1'b1;
                    for (int k = 0; k < len; k++) begin
                        if (!tbl_care[p][k]) continue;
                        seen = (k == len - 1) ? r.data_byte : recent_bytes[len - 2 - k];
                        if (seen != tbl_value[p][k]) ok = 1'b0;
                    end
                    if (!ok) continue;
                    found[n_hits].hit_pattern = 2'(p);
                    found[n_hits].hit_offset  =
                        32'(next_offset - mwbm_pkg::OFFSET_BITS'(len - 1));
                    found[n_hits].last_hit    = 1'b0;
                    n_hits++;
                end
                if (n_hits > 0) found[n_hits - 1].last_hit = 1'b1;
                for (int i = 0; i < n_hits; i++) expected_hits.push_back(found[i]);
                for (int i = mwbm_pkg::HIST_DEPTH - 1; i > 0; i--)
                    recent_bytes[i] = recent_bytes[i - 1];
                recent_bytes[0] = r.data_byte;
                if (next_offset != '1) next_offset++;   // offset saturates
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Request side. Fields a request type does not use carry random noise.
    // ---------------------------------------------------------------------
    function automatic mwbm_pkg::t_req noise_req();
        logic [$bits(mwbm_pkg::t_req)-1:0] raw;
        raw = $bits(mwbm_pkg::t_req)'($urandom);
        return raw;
    endfunction

    // Valid is left high on return so back-to-back requests need no gap;
    // anything that stops sending must lower it first.
    task automatic send_req(input mwbm_pkg::t_req r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (o_req_stall);
        apply_request(r);
        reqs_sent++;
    endtask

    task automatic send_load(input int p, input int pos, input logic [7:0] val,
                             input logic care);
        mwbm_pkg::t_req r;
        r = noise_req();
        r.req_type      = mwbm_pkg::REQ_LOAD;
        r.pattern_index = 2'(p);
        r.byte_position = 4'(pos);
        r.pattern_byte  = val;
        r.care          = care;
        send_req(r);
    endtask

    task automatic send_length(input int p, input int len);
        mwbm_pkg::t_req r;
        r = noise_req();
        r.req_type       = mwbm_pkg::REQ_LENGTH;
        r.pattern_index  = 2'(p);
        r.pattern_length = 5'(len);
        send_req(r);
    endtask

    task automatic send_data(input logic [7:0] b);
        mwbm_pkg::t_req r;
        r = noise_req();
        r.req_type  = mwbm_pkg::REQ_DATA;
        r.data_byte = b;
        send_req(r);
    endtask

    task automatic send_restart();
        mwbm_pkg::t_req r;
        r = noise_req();
        r.req_type = mwbm_pkg::REQ_RESTART;
        send_req(r);
    endtask

    // Stop requesting and wait for every owed hit, then let the pipe settle.
    task automatic drain_hits();
        int spins;
        spins = 0;
        i_req_valid <= 1'b0;
        while (expected_hits.size() != 0 && spins < 20000) begin
            @(posedge i_clk);
            spins++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Hit side: random stall, or a long hold-off when a test asks for one.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (holdoff_asked != holdoff_served) begin
            holdoff_served = holdoff_asked;
            holdoff_left   = HOLDOFF_LEN;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_hit_stall <= 1'b1;
        end else begin
            i_hit_stall <= ($urandom_range(0, 99) < hit_stall_pct);
        end
    end

    // Each accepted hit against the oldest prediction, field by field.
    always @(posedge i_clk) begin
        mwbm_pkg::t_hit want;
        if (i_rst_n && o_hit_valid && !i_hit_stall) begin
            if (expected_hits.size() == 0) begin
                report_error($sformatf("unexpected hit: pattern %0d offset %0d last %0b",
                                       o_hit.hit_pattern, o_hit.hit_offset, o_hit.last_hit));
            end else begin
                want = expected_hits.pop_front();
                if (o_hit.hit_pattern !== want.hit_pattern)
                    report_error($sformatf("hit_pattern %0d, predicted %0d",
                                           o_hit.hit_pattern, want.hit_pattern));
                if (o_hit.hit_offset !== want.hit_offset)
                    report_error($sformatf("hit_offset %0d, predicted %0d (pattern %0d)",
                                           o_hit.hit_offset, want.hit_offset,
                                           want.hit_pattern));
                if (o_hit.last_hit !== want.last_hit)
                    report_error($sformatf("last_hit %0b, predicted %0b (pattern %0d)",
                                           o_hit.last_hit, want.last_hit,
                                           want.hit_pattern));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // After reset every length is zero, so extreme bytes must give nothing.
    task automatic test_disabled_table();
        send_data(8'h00);
        send_data(8'hFF);
    endtask

    // Care bits reset to zero: four length-one patterns all hit one byte,
    // giving the full four hits with last_hit on the final one.
    task automatic test_all_wildcards();
        for (int p = 0; p < mwbm_pkg::PATTERNS; p++) send_length(p, 1);
        send_data(8'hA5);
    endtask

    // "A?C" in pattern 1, the middle byte left as a wildcard.
    task automatic test_wildcard_gap();
        send_load(1, 0, 8'h41, 1'b1);
        send_load(1, 2, 8'h43, 1'b1);
        send_length(1, 3);
        send_length(0, 0);
        send_length(2, 0);
        send_length(3, 0);
        send_data(8'h41);
        send_data(8'h7E);
        send_data(8'h43);
    endtask

    // Restart clears history and offset but keeps the table; a two-byte
    // all-wildcard pattern must wait for a second byte before it can hit.
    task automatic test_restart_short_stream();
        send_restart();
        send_length(2, 2);
        send_data(8'h41);
        send_data(8'h7E);
        send_data(8'h43);
    endtask

    // Length 31 clamps to 16; only the last byte is cared, so it fires on 0xFF
    // once sixteen bytes have streamed (in the later tests).
    task automatic test_overlong_length();
        send_load(3, 15, 8'hFF, 1'b1);
        send_load(3, 0, 8'h00, 1'b0);
        send_length(3, 31);
    endtask

    // Hold the hit side off while every byte hits, so the hit queue fills
    // and the request stall has to rise.
    task automatic test_backpressure();
        send_load(0, 0, 8'h00, 1'b0);
        send_length(0, 1);
        holdoff_asked++;
        for (int i = 0; i < 14; i++) send_data(8'($urandom));
        drain_hits();
    endtask

    function automatic logic [7:0] pick_byte();
        // mostly a small alphabet so that random data meets the patterns
        return ($urandom_range(0, 99) < 75) ? 8'($urandom_range(0, 7)) : 8'($urandom);
    endfunction

    // Mostly pattern occurrences with random wildcard content, mixed with
    // reprogramming mid-stream, restarts and loose bytes.
    task automatic test_random_traffic(input int n_reqs, input int idle_pct,
                                       input int stall_pct);
        int stop_at;
        int pick;
        int p;
        int len;
        send_idle_pct = idle_pct;
        hit_stall_pct = stall_pct;
        stop_at = reqs_sent + n_reqs;
        while (reqs_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            p    = $urandom_range(0, mwbm_pkg::PATTERNS - 1);
            if (pick < 6) begin
                pick = $urandom_range(0, 99);
                if (pick < 10)      len = 0;
                else if (pick < 70) len = $urandom_range(1, 4);
                else if (pick < 90) len = $urandom_range(5, 8);
                else                len = $urandom_range(mwbm_pkg::MAX_PATTERN_LEN + 1, 31);
                for (int k = 0; k < len && k < 6; k++)
                    send_load(p, k, pick_byte(), $urandom_range(0, 99) < 80);
                send_length(p, len);
            end else if (pick < 10) begin
                send_restart();
            end else if (pick < 16) begin
                send_load(p, $urandom_range(0, mwbm_pkg::MAX_PATTERN_LEN - 1), pick_byte(),
                          1'($urandom));
            end else if (pick < 60 && tbl_len[p] != 0) begin
                len = tbl_len[p];
                for (int k = 0; k < len; k++)
                    send_data(tbl_care[p][k] ? tbl_value[p][k] : pick_byte());
            end else begin
                send_data(pick_byte());
            end
        end
        drain_hits();
    endtask

    initial begin
        clear_matcher_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_disabled_table();
        test_all_wildcards();
        test_wildcard_gap();
        test_restart_short_stream();
        test_overlong_length();
        drain_hits();
        test_backpressure();

        test_random_traffic(16, 0, 0);
        test_random_traffic(16, 60, 0);
        test_random_traffic(16, 0, 60);
        test_random_traffic(16, 7, 7);

        if (expected_hits.size() != 0)
            report_error($sformatf("%0d predicted hits never arrived", expected_hits.size()));
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
